>>> rtl/ddg_pkg.sv
// Shared types, constants and the 3x5 digit font for the decimal glyph renderer.
`default_nettype none

package ddg_pkg;

    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_BITS  = 4;
    localparam int BCD_BITS    = NUM_DIGITS * DIGIT_BITS;
    // Only non-negative values are converted, so the sign bit never enters the shifter.
    localparam int BIN_BITS    = 31;
    localparam int SHIFT_BITS  = 5;
    localparam int DIGIT_PITCH = 5;
    localparam int GLYPH_ROWS  = 5;
    localparam int ROW_BITS    = 3;
    localparam int POS_BITS    = 4;

    localparam logic [ROW_BITS-1:0]   LAST_GLYPH_ROW = ROW_BITS'(GLYPH_ROWS - 1);
    localparam logic [SHIFT_BITS-1:0] SHIFT_START    = SHIFT_BITS'(BIN_BITS - 1);

    typedef struct packed {
        logic load;     // capture a new word and clear the BCD register
        logic shift;    // one double-dabble step
        logic locate;   // find the leading digit and set up the row walk
        logic emit;     // present one glyph row and advance
    } ddg_cmd_t;

    typedef struct packed {
        logic in_neg;     // the word on the input ports is negative
        logic conv_done;  // this is the final conversion step
        logic emit_done;  // this is the final row of the final digit
    } ddg_status_t;

    // Glyph row mask; bit j lights column +j.
    function automatic logic [2:0] glyph_row(input logic [DIGIT_BITS-1:0] digit,
                                             input logic [ROW_BITS-1:0] row);
        logic [14:0] g;
        logic [2:0]  r;
        unique case (digit)
            4'd0:    g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1:    g = {3'd2, 3'd3, 3'd2, 3'd2, 3'd7};
            4'd2:    g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd3:    g = {3'd7, 3'd4, 3'd7, 3'd4, 3'd7};
            4'd4:    g = {3'd5, 3'd5, 3'd7, 3'd4, 3'd4};
            4'd5:    g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd6:    g = {3'd7, 3'd1, 3'd7, 3'd5, 3'd7};
            4'd7:    g = {3'd7, 3'd4, 3'd4, 3'd4, 3'd4};
            4'd8:    g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9:    g = {3'd7, 3'd5, 3'd7, 3'd4, 3'd7};
            default: g = 15'd0;
        endcase
        unique case (row)
            3'd0:    r = g[2:0];
            3'd1:    r = g[5:3];
            3'd2:    r = g[8:6];
            3'd3:    r = g[11:9];
            3'd4:    r = g[14:12];
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ddg_ctrl.sv
// Sequencer for the glyph renderer: accept, convert, locate, emit rows.
`default_nettype none

module ddg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire ddg_pkg::ddg_status_t status,
    output ddg_pkg::ddg_cmd_t         cmd,
    output logic                      busy
);
    import ddg_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CONV   = 2'd1;
    localparam logic [1:0] ST_LOCATE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    // A negative word produces no rows, so the block stays idle.
                    if (!status.in_neg)
                    begin
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_LOCATE;
                end
            end
            ST_LOCATE:
            begin
                cmd.locate = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/ddg_datapath.sv
// Datapath: double-dabble converter, digit and row walker, registered row outputs.
`default_nettype none

module ddg_datapath #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ddg_pkg::ddg_cmd_t     cmd,
    output ddg_pkg::ddg_status_t       status,
    input  wire logic [31:0]           value,
    input  wire logic [COORD_BITS-1:0] x_pos,
    input  wire logic [COORD_BITS-1:0] y_pos,
    output logic                       row_valid,
    output logic [COORD_BITS:0]        row_x,
    output logic [COORD_BITS:0]        row_y,
    output logic [2:0]                 row_bits,
    output logic                       last_row
);
    import ddg_pkg::*;

    localparam int CW = COORD_BITS + 1;

    logic [BIN_BITS-1:0]   bin_reg;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [SHIFT_BITS-1:0] cnt_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [CW-1:0]         x_reg;
    logic [CW-1:0]         colx_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [ROW_BITS-1:0]   row_reg;

    logic [BCD_BITS-1:0]   bcd_adj;
    logic [BCD_BITS-1:0]   bcd_next;
    logic [POS_BITS-1:0]   msd_pos;
    logic [DIGIT_BITS-1:0] cur_digit;
    logic                  final_row;

    logic            row_valid_reg;
    logic [CW-1:0]   row_x_reg;
    logic [CW-1:0]   row_y_reg;
    logic [2:0]      row_bits_reg;
    logic            last_row_reg;

    // One double-dabble step: add three to every digit of five or more, then shift.
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5)
            begin
                bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
                    bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end
        end
        bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[BIN_BITS-1]};
    end

    // Highest nonzero digit; zero keeps the single digit at position 0.
    always_comb
    begin
        msd_pos = '0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_BITS +: DIGIT_BITS] != '0)
            begin
                msd_pos = POS_BITS'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[pos_reg*DIGIT_BITS +: DIGIT_BITS];
    assign final_row = (pos_reg == '0) && (row_reg == LAST_GLYPH_ROW);

    assign status.in_neg    = value[31];
    assign status.conv_done = (cnt_reg == '0);
    assign status.emit_done = final_row;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= value[BIN_BITS-1:0];
            bcd_reg <= '0;
            cnt_reg <= SHIFT_START;
            x_reg   <= CW'(x_pos);
            y_reg   <= y_pos;
        end
        if (cmd.shift)
        begin
            bin_reg <= {bin_reg[BIN_BITS-2:0], 1'b0};
            bcd_reg <= bcd_next;
            cnt_reg <= cnt_reg - SHIFT_BITS'(1);
        end
        if (cmd.locate)
        begin
            pos_reg  <= msd_pos;
            row_reg  <= '0;
            colx_reg <= x_reg;
        end
        if (cmd.emit)
        begin
            row_x_reg    <= colx_reg;
            row_y_reg    <= CW'(y_reg) + CW'(row_reg);
            row_bits_reg <= glyph_row(cur_digit, row_reg);
            last_row_reg <= final_row;
            if (row_reg == LAST_GLYPH_ROW)
            begin
                row_reg  <= '0;
                pos_reg  <= pos_reg - POS_BITS'(1);
                colx_reg <= colx_reg + CW'(DIGIT_PITCH);
            end
            else
            begin
                row_reg <= row_reg + ROW_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= cmd.emit;
        end
    end

    assign row_valid = row_valid_reg;
    assign row_x     = row_x_reg;
    assign row_y     = row_y_reg;
    assign row_bits  = row_bits_reg;
    assign last_row  = last_row_reg & row_valid_reg;

endmodule

`default_nettype wire

>>> rtl/decimal_digit_glyph_renderer.sv
// Top level of the decimal glyph renderer: sequencer plus datapath.
//
//  channel  | handshake            | word
//  ---------+----------------------+-----------------------------------------
//  command  | start in, busy out   | value, x_pos, y_pos
//  rows     | row_valid out strobe | row_x, row_y, row_bits, last_row
//
// A word is taken when start is high and busy is low. A non-negative word
// keeps busy high through 31 double-dabble steps, a step that finds the leading
// digit, then one glyph row per cycle. Rows leave one per cycle through an
// output register; the last row shows in the first idle cycle, and a new word
// may be taken in that cycle. A negative word is taken and produces nothing.
// Reset clears the sequencer and the row strobe. The row receiver cannot stall
// the block.
`default_nettype none

module decimal_digit_glyph_renderer #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [31:0]           value,
    input  wire logic [COORD_BITS-1:0] x_pos,
    input  wire logic [COORD_BITS-1:0] y_pos,
    output logic                       row_valid,
    output logic [COORD_BITS:0]        row_x,
    output logic [COORD_BITS:0]        row_y,
    output logic [2:0]                 row_bits,
    output logic                       last_row
);
    import ddg_pkg::*;

    ddg_cmd_t    cmd;
    ddg_status_t status;

    ddg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ddg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .row_valid (row_valid),
        .row_x     (row_x),
        .row_y     (row_y),
        .row_bits  (row_bits),
        .last_row  (last_row)
    );

endmodule

`default_nettype wire

>>> rtl/ddg_checker.sv
// Port-level checks for the decimal glyph renderer, bound to the top level.
`default_nettype none

module ddg_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic value_sign,
    input wire logic row_valid,
    input wire logic last_row
);

    // A non-negative word always starts a conversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !value_sign |=> busy)
        else $error("non-negative word did not start a conversion");

    // A negative word is dropped without going busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && value_sign |=> !busy && !row_valid)
        else $error("negative word was not dropped");

    // Rows of one word come out back to back until the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !last_row |=> row_valid)
        else $error("gap inside a row burst");

    // The final row lands in the first idle cycle, never while still busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && last_row |-> !busy)
        else $error("final row shown while busy");

    // Rows other than the final one only appear while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !last_row |-> busy)
        else $error("row shown while idle");

endmodule

bind decimal_digit_glyph_renderer ddg_checker u_ddg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .value_sign (value[31]),
    .row_valid  (row_valid),
    .last_row   (last_row)
);

`default_nettype wire
